// ===== rtl/lmcs_pkg.sv =====
// shared types and codes for the line minor coordinate stepper
package lmcs_pkg;

  localparam int unsigned CoordW = 6;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_POINT      = 2'd0,
    KIND_HORIZONTAL = 2'd1,
    KIND_VERTICAL   = 2'd2,
    KIND_SLOPED     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_NONE = 2'd2
  } axis_e;

endpackage

// ===== rtl/lmcs_line_if.sv =====
// input channel: both endpoints of one line
interface lmcs_line_if;
  import lmcs_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/lmcs_minor_if.sv =====
// output channel: minor coordinate changes and line status
interface lmcs_minor_if;
  import lmcs_pkg::*;

  logic   valid;
  logic   ready;
  coord_t minor_value;
  logic   value_valid;
  kind_e  line_kind;
  axis_e  major_axis;
  logic   last;

  modport source (output valid, minor_value, value_valid, line_kind, major_axis, last,
                  input ready);
  modport sink   (input valid, minor_value, value_valid, line_kind, major_axis, last,
                  output ready);
endinterface

// ===== rtl/line_minor_coordinate_stepper_top.sv =====
// line minor coordinate stepper: classifies a line and walks its major axis
//
// line_i takes one line (two endpoints) per item; coordinates above COORD_MAX
// are saturated. minor_o returns, in order, every ceiling minor coordinate
// that differs from the one at the previous major step, walking from the
// lower major endpoint up to one below the upper one. The final item of a
// line has last set. A diagonal or point line, or a walk without any change,
// gives a single status item with value_valid low and last high.
// Sequence: accept in the idle state, compute the setup, walk one major step
// at a time (up to 62 steps) with an end check, then post the final item in
// the flush state. The rate is set by the step unit: one remainder update
// (add, range compare, correction) per cycle while the walk is not held.
// line_i.ready is high only while no line is in work. Items are posted
// through an output register; a stalled receiver holds the walk only when a
// new change has to be posted while the register is still full.
// Reset clears the sequencer and the output valid; no line is in work after.
module line_minor_coordinate_stepper_top #(
  parameter int unsigned COORD_MAX = 63
) (
  input  logic clk_i,
  input  logic rst_ni,
  lmcs_line_if.sink    line_i,
  lmcs_minor_if.source minor_o
);
  import lmcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  localparam coord_t CoordCap = coord_t'(COORD_MAX);

  function automatic coord_t clamp(input coord_t c);
    return (c > CoordCap) ? CoordCap : c;
  endfunction

  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  state_e state_q, state_d;
  coord_t px_q, py_q, qx_q, qy_q;
  coord_t pos_q, pos_d;
  coord_t hi_q, hi_d;
  coord_t minor_q, minor_d;
  coord_t rem_q, rem_d;
  coord_t span_q, span_d;
  logic signed [CoordW:0] slope_q, slope_d;
  kind_e  kind_q, kind_d;
  axis_e  axis_q, axis_d;
  coord_t pend_q, pend_d;
  logic   pend_vld_q, pend_vld_d;

  logic   out_vld_q, out_vld_d;
  coord_t out_val_q, out_val_d;
  logic   out_vv_q, out_vv_d;
  logic   out_last_q, out_last_d;
  kind_e  out_kind_q, out_kind_d;
  axis_e  out_axis_q, out_axis_d;
  logic   out_load;

  // setup signals
  coord_t adx, ady, lo_s, hi_s, mlo_s, mhi_s;
  kind_e  kind_s;
  axis_e  axis_s;

  // step unit
  logic signed [CoordW+1:0] rem_sub, span_s;
  coord_t rem_step, minor_step;
  logic   chg, at_end, out_free, accept;

  assign accept       = line_i.valid && line_i.ready;
  assign line_i.ready = (state_q == ST_IDLE);
  assign out_free     = !out_vld_q || minor_o.ready;

  always_comb begin
    adx = absdiff(px_q, qx_q);
    ady = absdiff(py_q, qy_q);
    priority if (adx == '0 && ady == '0) begin
      kind_s = KIND_POINT;
    end else if (ady == '0) begin
      kind_s = KIND_HORIZONTAL;
    end else if (adx == '0) begin
      kind_s = KIND_VERTICAL;
    end else begin
      kind_s = KIND_SLOPED;
    end
    priority if (adx == ady) begin
      axis_s = AXIS_NONE;
      lo_s = px_q; hi_s = qx_q; mlo_s = py_q; mhi_s = qy_q;
    end else if (ady > adx) begin
      axis_s = AXIS_Y;
      if (py_q < qy_q) begin
        lo_s = py_q; hi_s = qy_q; mlo_s = px_q; mhi_s = qx_q;
      end else begin
        lo_s = qy_q; hi_s = py_q; mlo_s = qx_q; mhi_s = px_q;
      end
    end else begin
      axis_s = AXIS_X;
      if (px_q < qx_q) begin
        lo_s = px_q; hi_s = qx_q; mlo_s = py_q; mhi_s = qy_q;
      end else begin
        lo_s = qx_q; hi_s = px_q; mlo_s = qy_q; mhi_s = py_q;
      end
    end
  end

  // remainder r = q*span - target stays in [0, span); target grows by slope per step
  always_comb begin
    rem_sub = $signed({2'b00, rem_q}) - $signed({slope_q[CoordW], slope_q});
    span_s  = $signed({2'b00, span_q});
    chg     = 1'b1;
    priority if (rem_sub < 0) begin
      rem_step   = coord_t'(rem_sub + span_s);
      minor_step = coord_t'(minor_q + 1'b1);
    end else if (rem_sub >= span_s) begin
      rem_step   = coord_t'(rem_sub - span_s);
      minor_step = coord_t'(minor_q - 1'b1);
    end else begin
      rem_step   = coord_t'(rem_sub);
      minor_step = minor_q;
      chg        = 1'b0;
    end
    at_end = ({1'b0, pos_q} + 1'b1) >= {1'b0, hi_q};
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    hi_d       = hi_q;
    minor_d    = minor_q;
    rem_d      = rem_q;
    span_d     = span_q;
    slope_d    = slope_q;
    kind_d     = kind_q;
    axis_d     = axis_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_load   = 1'b0;
    out_val_d  = out_val_q;
    out_vv_d   = out_vv_q;
    out_last_d = out_last_q;
    out_kind_d = out_kind_q;
    out_axis_d = out_axis_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        kind_d     = kind_s;
        axis_d     = axis_s;
        pos_d      = lo_s;
        hi_d       = hi_s;
        minor_d    = mlo_s;
        rem_d      = '0;
        span_d     = (axis_s == AXIS_Y) ? ady : adx;
        slope_d    = $signed({1'b0, mhi_s}) - $signed({1'b0, mlo_s});
        pend_vld_d = 1'b0;
        state_d    = (axis_s == AXIS_NONE) ? ST_FLUSH : ST_WALK;
      end
      ST_WALK: begin
        if (at_end) begin
          state_d = ST_FLUSH;
        end else if (!(chg && pend_vld_q && !out_free)) begin
          pos_d   = coord_t'(pos_q + 1'b1);
          rem_d   = rem_step;
          minor_d = minor_step;
          if (chg) begin
            pend_d     = minor_step;
            pend_vld_d = 1'b1;
            if (pend_vld_q) begin
              out_load   = 1'b1;
              out_val_d  = pend_q;
              out_vv_d   = 1'b1;
              out_last_d = 1'b0;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val_d  = pend_vld_q ? pend_q : '0;
          out_vv_d   = pend_vld_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_kind_d = kind_q;
      out_axis_d = axis_q;
    end
    out_vld_d = out_load || (out_vld_q && !minor_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= clamp(line_i.start_x);
      py_q <= clamp(line_i.start_y);
      qx_q <= clamp(line_i.end_x);
      qy_q <= clamp(line_i.end_y);
    end
    pos_q      <= pos_d;
    hi_q       <= hi_d;
    minor_q    <= minor_d;
    rem_q      <= rem_d;
    span_q     <= span_d;
    slope_q    <= slope_d;
    kind_q     <= kind_d;
    axis_q     <= axis_d;
    pend_q     <= pend_d;
    out_val_q  <= out_val_d;
    out_vv_q   <= out_vv_d;
    out_last_q <= out_last_d;
    out_kind_q <= out_kind_d;
    out_axis_q <= out_axis_d;
  end

  assign minor_o.valid       = out_vld_q;
  assign minor_o.minor_value = out_val_q;
  assign minor_o.value_valid = out_vv_q;
  assign minor_o.line_kind   = out_kind_q;
  assign minor_o.major_axis  = out_axis_q;
  assign minor_o.last        = out_last_q;

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rem_q < span_q))
    else $error("step remainder out of range");

  a_pos_below_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (pos_q < hi_q))
    else $error("walk position reached upper endpoint");

  a_minor_unit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |=> (minor_q == $past(minor_q)
      || minor_q == coord_t'($past(minor_q) + 1'b1)
      || minor_q == coord_t'($past(minor_q) - 1'b1)))
    else $error("minor coordinate moved more than one per step");

  a_flush_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free) |=> (state_q == ST_IDLE && out_vld_q && out_last_q))
    else $error("line end not posted with last");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_vv_q) |-> (out_last_q && out_val_q == '0))
    else $error("status item malformed");

endmodule
